// ===== rtl/cil_pkg.sv =====
// Shared types and constants for the code point inversion list membership block.
// No dependencies; imported by every module of the block except cil_ram.
package cil_pkg;

    localparam int CODE_W = 21;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 11;

    // first value past the last valid code point
    localparam logic [CODE_W-1:0] CP_LIMIT = 21'h110000;

    // command codes on the request word
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // request word
    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [CODE_W-1:0] code_value;
    } cil_req_t;

    // response word
    typedef struct packed {
        logic             is_member;
        logic [POS_W-1:0] range_position;
    } cil_rsp_t;

    // operation kinds after classification
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_REJECT = 2'd1,
        OP_SEARCH = 2'd2
    } cil_op_kind_t;

    // classified operation carried through the queue
    typedef struct packed {
        cil_op_kind_t      kind;
        logic [IDX_W-1:0]  entry_index;
        logic [CODE_W-1:0] code_value;
        logic [POS_W-1:0]  last_pos;
    } cil_op_t;

    // back end sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FIRST  = 5'b00010,
        ST_LAST   = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_RESULT = 5'b10000
    } cil_state_t;

endpackage

// ===== rtl/codepoint_inversion_list_membership_core.sv =====
// Top level of the code point inversion list membership block.
// Depends on cil_pkg, cil_front, cil_queue, cil_back and cil_ram.
//
// Usage:
//   req channel (req_valid / req_stall / req_word) carries loads and queries.
//   A load writes one boundary into the table and gives no response; a load
//   whose entry_index is at or past the table depth is dropped.
//   A query gives one response word on the rsp channel (rsp_valid /
//   rsp_stall / rsp_word): is_member and range_position.
//   cfg_we / cfg_wdata write the list length; write it only while idle.
// Operation sequence:
//   A query enters the queue, is issued, is tested against the first entry
//   and then the next-to-last entry, runs the bisection steps (up to log2 of
//   the list length, 10 at 1024 entries) and loads the response register;
//   either early test can decide it. A rejected query goes from issue
//   straight to the response register, and a load writes the table on issue.
//   The single read port of the boundary table sets the pace, one read per
//   cycle while a search runs. The back end finishes one operation first.
// Reset and stall:
//   Reset clears the list length and empties queue and response register;
//   the table contents are undefined until loaded. When rsp_stall is high
//   the response holds, the two-entry queue keeps taking requests until it
//   fills, and then req_stall rises.
module codepoint_inversion_list_membership_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cil_pkg::POS_W-1:0] cfg_wdata,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  cil_pkg::cil_req_t         req_word,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output cil_pkg::cil_rsp_t         rsp_word
);
    import cil_pkg::*;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_valid;
    cil_op_t push_op;
    cil_op_t head_op;

    // classify incoming words
    cil_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    // decoupling queue
    cil_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (push_op),
        .pop        (q_pop),
        .head_op    (head_op),
        .head_valid (q_valid),
        .full       (q_full)
    );

    // table and search engine
    cil_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (head_op),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

// ===== rtl/cil_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cil_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cil_front.sv =====
// Front end: holds the list length register, accepts request words and
// classifies them into load, reject or search operations. Uses cil_pkg.
module cil_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cil_pkg::POS_W-1:0]  cfg_wdata,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  cil_pkg::cil_req_t          req_word,
    input  logic                       q_full,
    output logic                       q_push,
    output cil_pkg::cil_op_t           q_op
);
    import cil_pkg::*;

    logic [POS_W-1:0] list_length_reg;
    logic [POS_W-1:0] len_sat;
    logic             accept;
    logic             drop;

    // list length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            list_length_reg <= cfg_wdata;
        end
    end

    // length clipped to the table depth
    assign len_sat = (list_length_reg > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : list_length_reg;

    assign req_stall = q_full;
    assign accept    = req_valid && !req_stall;

    // loads past the table are dropped here
    assign drop   = (req_word.cmd == CMD_LOAD) && (req_word.entry_index >= TABLE_DEPTH);
    assign q_push = accept && !drop;

    // classification
    always_comb
    begin
        q_op.entry_index = req_word.entry_index;
        q_op.code_value  = req_word.code_value;
        q_op.last_pos    = len_sat - 1'b1;
        if (req_word.cmd == CMD_LOAD)
        begin
            q_op.kind = OP_LOAD;
        end
        else if ((req_word.code_value >= CP_LIMIT) || (len_sat == '0))
        begin
            q_op.kind = OP_REJECT;
        end
        else
        begin
            q_op.kind = OP_SEARCH;
        end
    end

endmodule

// ===== rtl/cil_queue.sv =====
// Two-entry queue of classified operations between front and back end.
// Uses cil_pkg.
module cil_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cil_pkg::cil_op_t push_op,
    input  logic             pop,
    output cil_pkg::cil_op_t head_op,
    output logic             head_valid,
    output logic             full
);
    import cil_pkg::*;

    cil_op_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/cil_back.sv =====
// Back end: executes loads into the boundary table and runs the search
// sequencer for queries, one table read per cycle while searching. Uses cil_pkg and cil_ram.
module cil_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  cil_pkg::cil_op_t q_op,
    output logic             q_pop,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output cil_pkg::cil_rsp_t rsp_word
);
    import cil_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    cil_state_t        state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic [POS_W-1:0]  mid_reg, mid_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              rsp_valid_reg, rsp_valid_next;
    cil_rsp_t          rsp_word_reg, rsp_word_next;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CODE_W-1:0] ram_rdata;
    logic              rsp_free;

    logic              below;
    logic [POS_W-1:0]  lo_sel;
    logic [POS_W-1:0]  hi_sel;
    logic [POS_W:0]    span_sum;
    logic [POS_W-1:0]  mid_calc;
    logic [POS_W-1:0]  mid_first;

    // boundary table
    cil_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(q_op.entry_index)),
        .wdata (q_op.code_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // one bisection step
    assign below     = (code_reg < ram_rdata);
    assign lo_sel    = below ? lo_reg : mid_reg;
    assign hi_sel    = below ? mid_reg : hi_reg;
    assign span_sum  = {1'b0, lo_sel} + {1'b0, hi_sel};
    assign mid_calc  = span_sum[POS_W:1];
    assign mid_first = hi_reg >> 1;

    // search sequencer
    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_op.kind)
                        OP_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        OP_REJECT:
                        begin
                            pos_next   = '0;
                            state_next = ST_RESULT;
                        end
                        OP_SEARCH:
                        begin
                            code_next  = q_op.code_value;
                            hi_next    = q_op.last_pos;
                            lo_next    = '0;
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = ST_FIRST;
                        end
                        default:
                        begin
                            pos_next   = '0;
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_FIRST:
            begin
                // early test against the first boundary
                if (below)
                begin
                    pos_next   = '0;
                    state_next = ST_RESULT;
                end
                else if (hi_reg == '0)
                begin
                    pos_next   = hi_reg;
                    state_next = ST_RESULT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ADDR_W'(hi_reg - 1'b1);
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // test against the next-to-last boundary
                if (!below)
                begin
                    pos_next   = hi_reg;
                    state_next = ST_RESULT;
                end
                else if (mid_first == '0)
                begin
                    pos_next   = hi_reg;
                    state_next = ST_RESULT;
                end
                else
                begin
                    mid_next   = mid_first;
                    ram_re     = 1'b1;
                    ram_raddr  = ADDR_W'(mid_first);
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                lo_next = lo_sel;
                hi_next = hi_sel;
                if (mid_calc == lo_sel)
                begin
                    pos_next   = hi_sel;
                    state_next = ST_RESULT;
                end
                else
                begin
                    mid_next  = mid_calc;
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(mid_calc);
                end
            end
            ST_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_word_next.is_member      = pos_reg[0];
                    rsp_word_next.range_position = pos_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        pos_reg      <= pos_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

// ===== rtl/cil_checker.sv =====
// Port-level checker for the code point inversion list membership block,
// bound to the top level. Uses cil_pkg.
module cil_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_stall,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input cil_pkg::cil_rsp_t         rsp_word
);
    import cil_pkg::*;

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("response changed while stalled");

    // membership follows the parity of the position
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.is_member == rsp_word.range_position[0])
        else $error("is_member does not match range_position parity");

    // position stays inside the table
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_word.range_position < TABLE_DEPTH)
        else $error("range_position beyond table depth");

    // queue is empty on the first edge out of reset
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !req_stall)
        else $error("request stalled right after reset");

endmodule

bind codepoint_inversion_list_membership_core cil_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_cil_checker (.*);

// ===== tb/cil_lookup_checker.sv =====
// Checker for the inversion list membership core: watches the register port and both word channels.
// Predicts each query answer from its own copy of the boundary table and length, compares, counts errors.
// Depends on cil_pkg.
module cil_lookup_checker #(
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [cil_pkg::POS_W-1:0] cfg_wdata,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  cil_pkg::cil_req_t         req_word,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  cil_pkg::cil_rsp_t         rsp_word,
    input  logic                      end_check,
    output int                        errors,
    output int                        pending,
    output int                        answers_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import cil_pkg::*;

    logic [CODE_W-1:0] bound_mem [DEPTH];
    logic [POS_W-1:0]  length_reg;
    cil_rsp_t          answer_q [$];

    // smallest index whose boundary exceeds cp: first entry, next-to-last entry, then bisection
    function automatic logic [POS_W-1:0] bisect_position(input logic [CODE_W-1:0] cp,
                                                         input int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n - 1;
        if (cp < bound_mem[0])
            return '0;
        if (hi == 0)
            return POS_W'(hi);
        if (cp >= bound_mem[hi - 1])
            return POS_W'(hi);
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (cp < bound_mem[mid])
                hi = mid;
            else
                lo = mid;
        end
        return POS_W'(hi);
    endfunction

    // out-of-range code points and an empty list are rejected, length saturates at the depth
    function automatic cil_rsp_t predict_answer(input logic [CODE_W-1:0] cp);
        cil_rsp_t    ans;
        int unsigned n;
        n   = (length_reg > DEPTH) ? DEPTH : length_reg;
        ans = '0;
        if (cp < CP_LIMIT && n != 0)
        begin
            ans.range_position = bisect_position(cp, n);
            ans.is_member      = ans.range_position[0];
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cil_rsp_t want;
        if (!rst_n)
        begin
            length_reg = '0;
            answer_q.delete();
            pending = 0;
        end
        else
        begin
            // list length write
            if (cfg_we)
                length_reg = cfg_wdata;

            // accepted request word: load updates the table, query queues its answer
            if (req_valid && !req_stall)
            begin
                if (req_word.cmd == CMD_LOAD)
                begin
                    if (req_word.entry_index < DEPTH)
                        bound_mem[req_word.entry_index] = req_word.code_value;
                end
                else
                    answer_q.push_back(predict_answer(req_word.code_value));
            end

            // accepted response word against the oldest answer
            if (rsp_valid && !rsp_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: answer with none expected: member %0d position %0d",
                             $time, rsp_word.is_member, rsp_word.range_position);
                end
                else
                begin
                    want = answer_q.pop_front();
                    answers_checked++;
                    if (rsp_word.is_member !== want.is_member)
                    begin
                        errors++;
                        $display("%0t: is_member expected %0d got %0d", $time,
                                 want.is_member, rsp_word.is_member);
                    end
                    if (rsp_word.range_position !== want.range_position)
                    begin
                        errors++;
                        $display("%0t: range_position expected %0d got %0d", $time,
                                 want.range_position, rsp_word.range_position);
                    end
                end
            end

            // answers still owed at the end of the run
            if (end_check && answer_q.size() != 0)
            begin
                errors += answer_q.size();
                $display("%0t: %0d answers never arrived, oldest expected member %0d position %0d",
                         $time, answer_q.size(), answer_q[0].is_member,
                         answer_q[0].range_position);
                answer_q.delete();
            end

            pending = answer_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for codepoint_inversion_list_membership_core: clock, reset, stimulus and verdict.
// Depends on cil_pkg, the core RTL and cil_lookup_checker, which does all prediction and comparison.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cil_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int MAX_LENGTH   = 2047;
    localparam int RANDOM_WORDS = 700;
    localparam int SETTLE       = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic [CODE_W-1:0] CODE_MAX = 21'h1FFFFF;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [POS_W-1:0] cfg_wdata = '0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    cil_req_t         req_word  = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    cil_rsp_t         rsp_word;
    logic             end_check = 1'b0;
    bit               no_gaps   = 1'b0;

    int errors;
    int pending;
    int answers_checked;
    int cycle_cnt    = 0;
    int load_cnt     = 0;
    int query_cnt    = 0;
    int length_cnt   = 0;
    int random_words = 0;

    // boundaries as loaded, used only to aim queries at range edges
    logic [CODE_W-1:0] shadow_bounds [DEPTH];

    codepoint_inversion_list_membership_core #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    cil_lookup_checker #(
        .DEPTH (DEPTH)
    ) chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req_word        (req_word),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp_word        (rsp_word),
        .end_check       (end_check),
        .errors          (errors),
        .pending         (pending),
        .answers_checked (answers_checked)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("** codepoint_inversion_list_membership_core: FAILED **");
            $finish;
        end
    end

    // response side stalls at random except in the gap-free stretch
    always @(negedge clk)
        rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 30);

    // present one request word at a falling edge and hold it until it is taken
    task automatic push_word(input cil_req_t w);
        while (!no_gaps && $urandom_range(0, 99) < 30)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_load(input int idx, input logic [CODE_W-1:0] val);
        cil_req_t w;
        w.cmd         = CMD_LOAD;
        w.entry_index = IDX_W'(idx);
        w.code_value  = val;
        shadow_bounds[idx] = val;
        load_cnt++;
        push_word(w);
    endtask

    // entry_index is don't-care on a query, so it carries random bits
    task automatic send_query(input logic [CODE_W-1:0] cp);
        cil_req_t w;
        w.cmd         = CMD_QUERY;
        w.entry_index = IDX_W'($urandom_range(0, DEPTH - 1));
        w.code_value  = cp;
        query_cnt++;
        push_word(w);
    endtask

    // stop sending until every answer is back, then let in-flight loads finish
    task automatic wait_for_answers(input int settle);
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (settle) @(negedge clk);
    endtask

    // length changes only with the core idle
    task automatic set_length(input int len);
        wait_for_answers(SETTLE);
        cfg_we    <= 1'b1;
        cfg_wdata <= POS_W'(len);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        length_cnt++;
    endtask

    // load entries 0..n-1: ascending ending in CP_LIMIT, or raw noise
    task automatic fill_table(input int n, input bit sorted);
        int unsigned span;
        int unsigned v;
        span = CP_LIMIT / n;
        v    = $urandom_range(0, span);
        for (int i = 0; i < n - 1; i++)
        begin
            if (sorted)
            begin
                send_load(i, CODE_W'((v >= CP_LIMIT) ? CP_LIMIT - 1 : v));
                v += $urandom_range(0, 2 * span);
            end
            else
                send_load(i, CODE_W'($urandom_range(0, CODE_MAX)));
        end
        send_load(n - 1, sorted ? CP_LIMIT : CODE_W'($urandom_range(0, CODE_MAX)));
    endtask

    // query mix: out of range, extremes, near a boundary, anywhere valid
    function automatic logic [CODE_W-1:0] pick_code(input int used);
        int                r;
        logic [CODE_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 10)
            return CODE_W'($urandom_range(CP_LIMIT, CODE_MAX));
        if (r < 18)
            return ($urandom_range(0, 1) == 1) ? CODE_W'(CP_LIMIT - 1) : '0;
        if (r < 65 && used > 0)
        begin
            b = shadow_bounds[$urandom_range(0, used - 1)];
            return CODE_W'(b + $urandom_range(0, 2) - 1);
        end
        return CODE_W'($urandom_range(0, CP_LIMIT - 1));
    endfunction

    initial
    begin
        int phase;
        int pick;
        int len;
        int used;
        int nq;
        int drain_at;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list rejects everything
        set_length(0);
        send_query('0);
        send_query(CODE_W'(CP_LIMIT - 1));
        send_query(CODE_MAX);

        // small letter-range table, plus the top entry with all value bits set
        send_load(0, 21'h41);
        send_load(1, 21'h5B);
        send_load(2, 21'h61);
        send_load(3, 21'h7B);
        send_load(4, CP_LIMIT);
        send_load(DEPTH - 1, CODE_MAX);
        set_length(5);
        send_query('0);
        send_query(21'h41);
        send_query(21'h5A);
        send_query(21'h5B);
        send_query(21'h7A);
        send_query(21'h7B);
        send_query(CODE_W'(CP_LIMIT - 1));
        send_query(CP_LIMIT);

        // single entry: never a member
        set_length(1);
        send_query(21'h50);
        send_query(21'h20);

        // random phases; entries 0..4 are already loaded, saturated lengths wait until
        // phase 2 has loaded the whole table, so every length only reads loaded entries
        for (phase = 0; random_words < RANDOM_WORDS; phase++)
        begin
            pick = $urandom_range(0, 99);
            if (phase == 0)
                len = 2;
            else if (phase == 2)
                len = DEPTH;
            else if (phase == 4)
                len = MAX_LENGTH;
            else if (pick < 10)
                len = $urandom_range(0, 1);
            else if (pick < 18 && phase > 2)
                len = $urandom_range(DEPTH + 1, MAX_LENGTH);
            else if (pick < 26)
                len = $urandom_range(64, 256);
            else
                len = $urandom_range(2, 40);
            set_length(len);
            used = (len > DEPTH) ? DEPTH : len;

            // full sorted table once, later saturated lengths reuse what is left of it
            if (phase == 2)
                fill_table(DEPTH, 1'b1);
            else if (used >= 2 && used <= 256)
            begin
                fill_table(used, $urandom_range(0, 99) < 85);
                random_words += used;
            end

            no_gaps  = (phase == 3);
            nq       = $urandom_range(8, 48);
            drain_at = (phase == 1 || $urandom_range(0, 3) == 0) ? $urandom_range(1, nq - 1) : -1;
            for (int k = 0; k < nq; k++)
            begin
                if (k == drain_at)
                    wait_for_answers(0);
                if ($urandom_range(0, 99) < 8)
                    send_load($urandom_range(0, DEPTH - 1), CODE_W'($urandom_range(0, CODE_MAX)));
                else
                    send_query(pick_code(used));
                random_words++;
            end
        end
        no_gaps = 1'b0;

        // drain, then settle out remaining loads
        wait_for_answers(SETTLE);
        end_check <= 1'b1;
        @(negedge clk);
        end_check <= 1'b0;
        @(negedge clk);

        $display("covered %0d loads and %0d queries over %0d length settings, empty to saturated",
                 load_cnt, query_cnt, length_cnt);
        $display("compared %0d answers with random gaps and stalls on both channels",
                 answers_checked);
        if (errors == 0)
            $display("** codepoint_inversion_list_membership_core: PASSED **");
        else
            $display("** codepoint_inversion_list_membership_core: FAILED **");
        $finish;
    end

endmodule

// ===== codepoint_inversion_list_membership_core.f =====
rtl/cil_pkg.sv
rtl/cil_ram.sv
rtl/cil_front.sv
rtl/cil_queue.sv
rtl/cil_back.sv
rtl/codepoint_inversion_list_membership_core.sv
rtl/cil_checker.sv
tb/cil_lookup_checker.sv
tb/tb.sv
